// ----- rtl/tiny_register_machine_executor_unit_macros.svh -----
// Assertion macros shared by the executor checker.
`ifndef TINY_REGISTER_MACHINE_EXECUTOR_UNIT_MACROS_SVH
`define TINY_REGISTER_MACHINE_EXECUTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TRME_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define TRME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/trme_pkg.sv -----
// Shared types and constants of the register machine executor.
package trme_pkg;

    localparam int DATA_W      = 32;
    localparam int ACT_W       = 3;
    localparam int REG_IDX_W   = 10;
    localparam int VAR_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ACT_W-1:0] act_t;

    localparam act_t ACT_LOAD  = 3'd0;
    localparam act_t ACT_LOADI = 3'd1;
    localparam act_t ACT_STORE = 3'd2;
    localparam act_t ACT_ADD   = 3'd3;
    localparam act_t ACT_SUB   = 3'd4;
    localparam act_t ACT_MUL   = 3'd5;
    localparam act_t ACT_READ  = 3'd6;
    localparam act_t ACT_WRITE = 3'd7;

    typedef struct packed {
        act_t                 action;
        logic                 wr_reg;
        logic                 a_ok;
        logic                 b_ok;
        logic                 var_ok;
        logic [REG_IDX_W-1:0] dest;
        logic [REG_IDX_W-1:0] src_a;
        logic [REG_IDX_W-1:0] src_b;
        logic [VAR_IDX_W-1:0] var_idx;
        logic [DATA_W-1:0]    data;
    } op_t;

endpackage

// ----- rtl/trme_if.sv -----
// Command and response channel interfaces of the register machine executor.
interface trme_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [trme_pkg::ACT_W-1:0]           action;
    logic [trme_pkg::REG_IDX_W-1:0]       dest_reg;
    logic [trme_pkg::REG_IDX_W-1:0]       src_reg_a;
    logic [trme_pkg::REG_IDX_W-1:0]       src_reg_b;
    logic [trme_pkg::VAR_IDX_W-1:0]       var_index;
    logic signed [trme_pkg::DATA_W-1:0]   immediate;
    logic signed [trme_pkg::DATA_W-1:0]   read_value;

    modport source (
        output valid, action, dest_reg, src_reg_a, src_reg_b, var_index, immediate, read_value,
        input  ready
    );
    modport sink (
        input  valid, action, dest_reg, src_reg_a, src_reg_b, var_index, immediate, read_value,
        output ready
    );
endinterface

interface trme_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 write_valid;
    logic [trme_pkg::VAR_IDX_W-1:0]       out_var;
    logic signed [trme_pkg::DATA_W-1:0]   out_value;
    logic [trme_pkg::DATA_W-1:0]          executed_count;

    modport source (
        output valid, write_valid, out_var, out_value, executed_count,
        input  ready
    );
    modport sink (
        input  valid, write_valid, out_var, out_value, executed_count,
        output ready
    );
endinterface

// ----- rtl/trme_front.sv -----
// Front end: accept commands and classify them into queue entries.
module trme_front #(
    parameter int REGISTER_COUNT = 1024,
    parameter int VARIABLE_COUNT = 5
) (
    trme_cmd_if.sink        cmd,
    output logic            push_valid,
    input  logic            push_ready,
    output trme_pkg::op_t   push_op
);

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;

    always_comb
    begin
        push_op.action  = cmd.action;
        push_op.dest    = cmd.dest_reg;
        push_op.src_a   = cmd.src_reg_a;
        push_op.src_b   = cmd.src_reg_b;
        push_op.var_idx = cmd.var_index;
        push_op.wr_reg  = (cmd.action inside {trme_pkg::ACT_LOAD, trme_pkg::ACT_LOADI,
                                              trme_pkg::ACT_ADD, trme_pkg::ACT_SUB,
                                              trme_pkg::ACT_MUL})
                          && (32'(cmd.dest_reg) < 32'(REGISTER_COUNT));
        push_op.a_ok    = 32'(cmd.src_reg_a) < 32'(REGISTER_COUNT);
        push_op.b_ok    = 32'(cmd.src_reg_b) < 32'(REGISTER_COUNT);
        push_op.var_ok  = 32'(cmd.var_index) < 32'(VARIABLE_COUNT);
        push_op.data    = (cmd.action == trme_pkg::ACT_READ) ? cmd.read_value : cmd.immediate;
    end

endmodule

// ----- rtl/trme_queue.sv -----
// Short queue between the front end and the execution back end.
module trme_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  trme_pkg::op_t   push_op,
    output logic            pop_valid,
    input  logic            pop_ready,
    output trme_pkg::op_t   pop_op
);

    trme_pkg::op_t                  slot_reg [trme_pkg::QUEUE_DEPTH];
    logic [trme_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [trme_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [trme_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                           push, pop;

    assign push_ready = (cnt_reg != trme_pkg::QCNT_W'(trme_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? trme_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? trme_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- rtl/trme_back.sv -----
// Back end: register file, variable store, execute stage and response register.
module trme_back #(
    parameter int REGISTER_COUNT = 1024,
    parameter int VARIABLE_COUNT = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  trme_pkg::op_t   q_op,
    trme_rsp_if.source      rsp
);

    localparam int AW = $clog2(REGISTER_COUNT);
    localparam int VW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;
    localparam int DW = trme_pkg::DATA_W;

    logic [DW-1:0]                  rf_mem [REGISTER_COUNT];
    logic [DW-1:0]                  mem_qa_reg, mem_qb_reg;

    logic [DW-1:0]                  var_reg [VARIABLE_COUNT];
    logic [DW-1:0]                  cnt_reg;

    logic                           e_valid_reg, e_fresh_reg;
    trme_pkg::op_t                  e_op_reg;
    logic [DW-1:0]                  e_opa_reg, e_opb_reg;

    logic                           o_valid_reg, o_pend_reg;
    logic [trme_pkg::REG_IDX_W-1:0] o_dest_reg;
    logic [DW-1:0]                  o_result_reg;
    logic                           o_wvalid_reg;
    logic [trme_pkg::VAR_IDX_W-1:0] o_var_reg;
    logic [DW-1:0]                  o_value_reg;
    logic [DW-1:0]                  o_count_reg;

    logic                           l_valid_reg;
    logic [trme_pkg::REG_IDX_W-1:0] l_dest_reg;
    logic [DW-1:0]                  l_data_reg;

    logic                           o_take, e_adv, e_free, issue;
    logic [DW-1:0]                  base_a, base_b, opa, opb, var_rd, res;
    logic                           var_wr;
    logic [DW-1:0]                  var_wdata;
    logic [VW-1:0]                  var_addr;

    assign o_take  = !o_valid_reg || rsp.ready;
    assign e_adv   = e_valid_reg && o_take;
    assign e_free  = !e_valid_reg || o_take;
    assign issue   = q_valid && e_free;
    assign q_ready = e_free;

    assign rsp.valid          = o_valid_reg;
    assign rsp.write_valid    = o_wvalid_reg;
    assign rsp.out_var        = o_var_reg;
    assign rsp.out_value      = o_value_reg;
    assign rsp.executed_count = o_count_reg;

    // register file: two read ports, one write port from the response stage
    always_ff @(posedge clk)
    begin
        mem_qa_reg <= rf_mem[AW'(q_op.src_a)];
        mem_qb_reg <= rf_mem[AW'(q_op.src_b)];
        if (o_pend_reg)
        begin
            rf_mem[AW'(o_dest_reg)] <= o_result_reg;
        end
    end

    // operand resolution: newest pending write first, then last write, then memory
    always_comb
    begin
        base_a = e_fresh_reg ? mem_qa_reg : e_opa_reg;
        base_b = e_fresh_reg ? mem_qb_reg : e_opb_reg;

        if (!e_op_reg.a_ok)
        begin
            opa = '0;
        end
        else if (o_pend_reg && (o_dest_reg == e_op_reg.src_a))
        begin
            opa = o_result_reg;
        end
        else if (l_valid_reg && (l_dest_reg == e_op_reg.src_a))
        begin
            opa = l_data_reg;
        end
        else
        begin
            opa = base_a;
        end

        if (!e_op_reg.b_ok)
        begin
            opb = '0;
        end
        else if (o_pend_reg && (o_dest_reg == e_op_reg.src_b))
        begin
            opb = o_result_reg;
        end
        else if (l_valid_reg && (l_dest_reg == e_op_reg.src_b))
        begin
            opb = l_data_reg;
        end
        else
        begin
            opb = base_b;
        end
    end

    always_comb
    begin
        var_addr  = VW'(e_op_reg.var_idx);
        var_rd    = e_op_reg.var_ok ? var_reg[var_addr] : '0;
        var_wr    = e_adv && e_op_reg.var_ok
                    && ((e_op_reg.action == trme_pkg::ACT_STORE)
                        || (e_op_reg.action == trme_pkg::ACT_READ));
        var_wdata = (e_op_reg.action == trme_pkg::ACT_STORE) ? opa : e_op_reg.data;

        case (e_op_reg.action)
            trme_pkg::ACT_LOAD:  res = var_rd;
            trme_pkg::ACT_LOADI: res = e_op_reg.data;
            trme_pkg::ACT_ADD:   res = opa + opb;
            trme_pkg::ACT_SUB:   res = opa - opb;
            trme_pkg::ACT_MUL:   res = opa * opb;
            default:             res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VARIABLE_COUNT; i++)
            begin
                var_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < VARIABLE_COUNT; i++)
            begin
                if (var_wr && (32'(var_addr) == 32'(i)))
                begin
                    var_reg[i] <= var_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_fresh_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_pend_reg  <= 1'b0;
            l_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (issue)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
            end
            e_fresh_reg <= issue;

            if (e_adv)
            begin
                o_valid_reg <= 1'b1;
                cnt_reg     <= cnt_reg + 32'd1;
            end
            else if (rsp.ready)
            begin
                o_valid_reg <= 1'b0;
            end
            o_pend_reg  <= e_adv && e_op_reg.wr_reg;
            l_valid_reg <= o_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            e_op_reg <= q_op;
        end
        e_opa_reg  <= opa;
        e_opb_reg  <= opb;
        l_dest_reg <= o_dest_reg;
        l_data_reg <= o_result_reg;
        if (e_adv)
        begin
            o_dest_reg   <= e_op_reg.dest;
            o_result_reg <= res;
            o_wvalid_reg <= (e_op_reg.action == trme_pkg::ACT_WRITE);
            o_var_reg    <= (e_op_reg.action == trme_pkg::ACT_WRITE) ? e_op_reg.var_idx : '0;
            o_value_reg  <= (e_op_reg.action == trme_pkg::ACT_WRITE) ? var_rd : '0;
            o_count_reg  <= cnt_reg + 32'd1;
        end
    end

endmodule

// ----- rtl/tiny_register_machine_executor_unit.sv -----
// Top level of the register machine executor.
// Queue, execute and response registers lie between a command and its response.
// Throughput: one command per cycle while rsp.ready is high, set by the single
// register file write port with forwarding of the pending and the last write.
// Reset clears the queue, the pipeline, the variable store and the count;
// the register file is not cleared.
module tiny_register_machine_executor_unit #(
    parameter int REGISTER_COUNT = 1024,
    parameter int VARIABLE_COUNT = 5
) (
    input  logic    clk,
    input  logic    rst_n,
    trme_cmd_if.sink    cmd,
    trme_rsp_if.source  rsp
);

    logic           push_valid, push_ready;
    trme_pkg::op_t  push_op;
    logic           pop_valid, pop_ready;
    trme_pkg::op_t  pop_op;

    trme_front #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .VARIABLE_COUNT (VARIABLE_COUNT)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    trme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    trme_back #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .VARIABLE_COUNT (VARIABLE_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_op    (pop_op),
        .rsp     (rsp)
    );

endmodule

// ----- rtl/trme_checker.sv -----
// Port-level checker of the register machine executor and its bind.
`include "tiny_register_machine_executor_unit_macros.svh"

module trme_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic                                write_valid,
    input  logic [trme_pkg::VAR_IDX_W-1:0]      out_var,
    input  logic [trme_pkg::DATA_W-1:0]         out_value,
    input  logic [trme_pkg::DATA_W-1:0]         executed_count
);

    logic [trme_pkg::DATA_W-1:0]    last_count_reg;
    logic [trme_pkg::DATA_W-1:0]    pending_reg, pending_next;
    logic                           cmd_acc, rsp_acc;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_acc && !rsp_acc)
        begin
            pending_next = pending_reg + 32'd1;
        end
        else if (rsp_acc && !cmd_acc)
        begin
            pending_next = pending_reg - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (rsp_acc)
            begin
                last_count_reg <= executed_count;
            end
        end
    end

    `TRME_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(executed_count) && $stable(out_value), "response dropped or changed while stalled")
    `TRME_ASSERT_NOW(a_count_step, clk, rst_n, rsp_valid, executed_count == last_count_reg + 32'd1, "executed count does not advance by one per transaction")
    `TRME_ASSERT_NOW(a_quiet_fields, clk, rst_n, rsp_valid && !write_valid, (out_var == '0) && (out_value == '0), "non-write response carries variable data")
    `TRME_ASSERT_NOW(a_no_invent, clk, rst_n, rsp_valid, pending_reg != '0, "response without an outstanding command")

endmodule

bind tiny_register_machine_executor_unit trme_checker u_trme_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .write_valid    (rsp.write_valid),
    .out_var        (rsp.out_var),
    .out_value      (rsp.out_value),
    .executed_count (rsp.executed_count)
);
